// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

  localparam int QueueDepth = 4;

  // Control register bit positions.
  localparam int BitInt   = 7;
  localparam int BitAcken = 6;
  localparam int BitStart = 5;
  localparam int BitStop  = 4;
  localparam int BitEn    = 2;
  localparam int BitIe    = 0;
  localparam logic [7:0] KeepMask = 8'h65;

  // Full status codes; the status register holds bits 7:3.
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StMtAddrAck  = 8'h18;
  localparam logic [7:0] StMtAddrNack = 8'h20;
  localparam logic [7:0] StMtDataAck  = 8'h28;
  localparam logic [7:0] StMtDataNack = 8'h30;
  localparam logic [7:0] StMrAddrAck  = 8'h40;
  localparam logic [7:0] StMrAddrNack = 8'h48;
  localparam logic [7:0] StMrDataAck  = 8'h50;
  localparam logic [7:0] StMrDataNack = 8'h58;
  localparam logic [7:0] StSrAddr     = 8'h60;
  localparam logic [7:0] StSrGenCall  = 8'h70;
  localparam logic [7:0] StSrDataAck  = 8'h80;
  localparam logic [7:0] StSrDataNack = 8'h88;
  localparam logic [7:0] StSrGcAck    = 8'h90;
  localparam logic [7:0] StSrGcNack   = 8'h98;
  localparam logic [7:0] StSrStop     = 8'hA0;
  localparam logic [7:0] StStAddr     = 8'hA8;
  localparam logic [7:0] StStDataAck  = 8'hB8;
  localparam logic [7:0] StStDataNack = 8'hC0;
  localparam logic [7:0] StStLastAck  = 8'hC8;
  localparam logic [4:0] StNone       = 5'h1F;

  localparam logic [7:0] DataReset = 8'hFF;
  localparam logic [6:0] OwnAddrReset = 7'h7F;

  typedef enum logic [2:0] {
    OP_CTRL_WRITE = 3'd0,
    OP_DATA_WRITE = 3'd1,
    OP_BUS_IDLE   = 3'd2,
    OP_ADDR_RECV  = 3'd3,
    OP_ADDR_ACK   = 3'd4,
    OP_TX_DONE    = 3'd5,
    OP_RX_DONE    = 3'd6,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PH_OTHER    = 3'd0,
    PH_WAITING  = 3'd1,
    PH_ADDRESS  = 3'd2,
    PH_TRANSMIT = 3'd3,
    PH_RECEIVE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_START     = 3'd2,
    CMD_RESET_ARB = 3'd3,
    CMD_SEND_ADDR = 3'd4,
    CMD_MASTER_TX = 3'd5,
    CMD_MASTER_RX = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_OWN_ADDRESS  = 2'd0,
    CFG_ADDRESS_MASK = 2'd1,
    CFG_GENCALL      = 2'd2
  } cfg_index_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic       ack_seen;
    logic       from_master;
    logic       start_granted;
    phase_t     phase;
    logic       data_write_ok;
    logic       slave_active;
  } item_t;

endpackage

// ===== rtl/tsc_front.sv =====
module tsc_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  // byte_value[7:0], ack_seen[8], from_master[9], start_granted[10],
  // master_phase[13:11], master_active[14], master_busy[15],
  // slave_active[16], slave_busy[17], zero[23:18]
  input  logic [23:0]         s_tdata,
  // op[2:0]
  input  logic [2:0]          s_tuser,
  input  logic                queue_full,
  output logic                push,
  output tsc_pkg::item_t      push_item
);

  logic master_active;
  logic master_busy;
  logic slave_active;
  logic slave_busy;

  assign master_active = s_tdata[14];
  assign master_busy   = s_tdata[15];
  assign slave_active  = s_tdata[16];
  assign slave_busy    = s_tdata[17];

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_item = '0;
    unique case (s_tuser)
      3'd0: push_item.op = tsc_pkg::OP_CTRL_WRITE;
      3'd1: push_item.op = tsc_pkg::OP_DATA_WRITE;
      3'd2: push_item.op = tsc_pkg::OP_BUS_IDLE;
      3'd3: push_item.op = tsc_pkg::OP_ADDR_RECV;
      3'd4: push_item.op = tsc_pkg::OP_ADDR_ACK;
      3'd5: push_item.op = tsc_pkg::OP_TX_DONE;
      3'd6: push_item.op = tsc_pkg::OP_RX_DONE;
      default: push_item.op = tsc_pkg::OP_NONE;
    endcase
    unique case (s_tdata[13:11])
      3'd1: push_item.phase = tsc_pkg::PH_WAITING;
      3'd2: push_item.phase = tsc_pkg::PH_ADDRESS;
      3'd3: push_item.phase = tsc_pkg::PH_TRANSMIT;
      3'd4: push_item.phase = tsc_pkg::PH_RECEIVE;
      default: push_item.phase = tsc_pkg::PH_OTHER;
    endcase
    push_item.byte_value    = s_tdata[7:0];
    push_item.ack_seen      = s_tdata[8];
    push_item.from_master   = s_tdata[9];
    push_item.start_granted = s_tdata[10];
    // A data write lands only while at least one engine part is active and idle.
    push_item.data_write_ok = (master_active && !master_busy) ||
                              (slave_active && !slave_busy);
    push_item.slave_active  = slave_active;
  end

endmodule

// ===== rtl/tsc_queue.sv =====
module tsc_queue #(
  parameter int DEPTH = tsc_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tsc_pkg::item_t head_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  tsc_pkg::item_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== rtl/tsc_back.sv =====
module tsc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [6:0]     cfg_data,
  input  logic           head_valid,
  input  tsc_pkg::item_t head_item,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  // command_byte[7:0], engine_enable[8], slave_ack_valid[9], slave_ack[10],
  // master_ack_valid[11], master_ack[12], status_code[17:13],
  // irq_request[18], data_value[26:19], control_value[34:27], zero[39:35]
  output logic [39:0]    m_tdata,
  // engine_command[2:0]
  output logic [2:0]     m_tuser
);

  logic [6:0] own_address;
  logic [6:0] address_mask;
  logic       gencall_enable;

  logic [7:0] control_bits, control_bits_next;
  logic       interrupt_flag, interrupt_flag_next;
  logic [4:0] status_value, status_value_next;
  logic [7:0] data_byte, data_byte_next;
  logic       general_call_mode, general_call_mode_next;
  logic       receive_direction, receive_direction_next;

  tsc_pkg::cmd_t cmd;
  logic [7:0] cbyte;
  logic       sav, sa, mav, ma;
  logic       acken;
  logic       clear;
  logic [6:0] addr;
  logic [7:0] bv;
  logic [7:0] ctrl_read;

  assign pop = head_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address    <= tsc_pkg::OwnAddrReset;
      address_mask   <= '0;
      gencall_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsc_pkg::CFG_OWN_ADDRESS:  own_address    <= cfg_data;
        tsc_pkg::CFG_ADDRESS_MASK: address_mask   <= cfg_data;
        tsc_pkg::CFG_GENCALL:      gencall_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    control_bits_next      = control_bits;
    interrupt_flag_next    = interrupt_flag;
    status_value_next      = status_value;
    data_byte_next         = data_byte;
    general_call_mode_next = general_call_mode;
    receive_direction_next = receive_direction;
    cmd   = tsc_pkg::CMD_NONE;
    cbyte = '0;
    sav   = 1'b0;
    sa    = 1'b0;
    mav   = 1'b0;
    ma    = 1'b0;
    clear = 1'b0;
    bv    = head_item.byte_value;
    addr  = bv[7:1];
    acken = control_bits[tsc_pkg::BitAcken];

    unique case (head_item.op)
      tsc_pkg::OP_CTRL_WRITE: begin
        control_bits_next = bv & tsc_pkg::KeepMask;
        if (bv[tsc_pkg::BitInt]) begin
          interrupt_flag_next = 1'b0;
          status_value_next   = tsc_pkg::StNone;
          clear = 1'b1;
        end else begin
          clear = !interrupt_flag;
        end
        if (bv[tsc_pkg::BitEn] && clear) begin
          if (bv[tsc_pkg::BitStop]) begin
            cmd = tsc_pkg::CMD_STOP;
          end else if (bv[tsc_pkg::BitStart]) begin
            cmd = tsc_pkg::CMD_START;
            if (head_item.start_granted) begin
              status_value_next   = tsc_pkg::StStart[7:3];
              interrupt_flag_next = 1'b1;
            end
          end else begin
            unique case (head_item.phase)
              tsc_pkg::PH_WAITING: cmd = tsc_pkg::CMD_RESET_ARB;
              tsc_pkg::PH_ADDRESS: begin
                receive_direction_next = data_byte[0];
                cmd   = tsc_pkg::CMD_SEND_ADDR;
                cbyte = data_byte;
              end
              tsc_pkg::PH_TRANSMIT: begin
                cmd   = tsc_pkg::CMD_MASTER_TX;
                cbyte = data_byte;
              end
              tsc_pkg::PH_RECEIVE: cmd = tsc_pkg::CMD_MASTER_RX;
              default: ;
            endcase
          end
        end
      end
      tsc_pkg::OP_DATA_WRITE: begin
        if (head_item.data_write_ok) begin
          data_byte_next = bv;
        end
      end
      tsc_pkg::OP_BUS_IDLE: begin
        if (control_bits[tsc_pkg::BitStart]) begin
          cmd = tsc_pkg::CMD_START;
          if (head_item.start_granted) begin
            status_value_next   = tsc_pkg::StStart[7:3];
            interrupt_flag_next = 1'b1;
          end
        end
        // A stop seen by an active slave overrides the start status.
        if (head_item.slave_active) begin
          status_value_next   = tsc_pkg::StSrStop[7:3];
          interrupt_flag_next = 1'b1;
        end
      end
      tsc_pkg::OP_ADDR_RECV: begin
        data_byte_next = bv;
        sav = 1'b1;
        if (acken) begin
          if (addr == '0) begin
            // General call is only taken for a write.
            if (!bv[0] && gencall_enable) begin
              sa = 1'b1;
              general_call_mode_next = 1'b1;
              receive_direction_next = 1'b1;
              status_value_next      = tsc_pkg::StSrGenCall[7:3];
              interrupt_flag_next    = 1'b1;
            end
          end else if ((addr | address_mask) == (own_address | address_mask)) begin
            sa = 1'b1;
            general_call_mode_next = 1'b0;
            receive_direction_next = !bv[0];
            status_value_next = !bv[0] ? tsc_pkg::StSrAddr[7:3] : tsc_pkg::StStAddr[7:3];
            interrupt_flag_next = 1'b1;
          end
        end
      end
      tsc_pkg::OP_ADDR_ACK: begin
        interrupt_flag_next = 1'b1;
        if (head_item.ack_seen) begin
          status_value_next = receive_direction ? tsc_pkg::StMrAddrAck[7:3]
                                                : tsc_pkg::StMtAddrAck[7:3];
        end else begin
          status_value_next = receive_direction ? tsc_pkg::StMrAddrNack[7:3]
                                                : tsc_pkg::StMtAddrNack[7:3];
        end
      end
      tsc_pkg::OP_TX_DONE: begin
        interrupt_flag_next = 1'b1;
        if (head_item.from_master) begin
          status_value_next = head_item.ack_seen ? tsc_pkg::StMtDataAck[7:3]
                                                 : tsc_pkg::StMtDataNack[7:3];
        end else if (!head_item.ack_seen) begin
          status_value_next = tsc_pkg::StStDataNack[7:3];
        end else begin
          status_value_next = acken ? tsc_pkg::StStDataAck[7:3]
                                    : tsc_pkg::StStLastAck[7:3];
        end
      end
      tsc_pkg::OP_RX_DONE: begin
        data_byte_next      = bv;
        interrupt_flag_next = 1'b1;
        if (head_item.from_master) begin
          mav = 1'b1;
          ma  = acken;
          status_value_next = acken ? tsc_pkg::StMrDataAck[7:3]
                                    : tsc_pkg::StMrDataNack[7:3];
        end else begin
          sav = 1'b1;
          sa  = acken;
          if (general_call_mode) begin
            status_value_next = acken ? tsc_pkg::StSrGcAck[7:3]
                                      : tsc_pkg::StSrGcNack[7:3];
          end else begin
            status_value_next = acken ? tsc_pkg::StSrDataAck[7:3]
                                      : tsc_pkg::StSrDataNack[7:3];
          end
        end
      end
      default: ;
    endcase

    ctrl_read = {interrupt_flag_next, control_bits_next[6:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits      <= '0;
      interrupt_flag    <= 1'b0;
      status_value      <= tsc_pkg::StNone;
      data_byte         <= tsc_pkg::DataReset;
      general_call_mode <= 1'b0;
      receive_direction <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (pop) begin
        control_bits      <= control_bits_next;
        interrupt_flag    <= interrupt_flag_next;
        status_value      <= status_value_next;
        data_byte         <= data_byte_next;
        general_call_mode <= general_call_mode_next;
        receive_direction <= receive_direction_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tuser <= cmd;
      m_tdata <= {5'd0, ctrl_read, data_byte_next,
                  interrupt_flag_next && control_bits_next[tsc_pkg::BitIe],
                  status_value_next, ma, mav, sa, sav,
                  control_bits_next[tsc_pkg::BitEn], cbyte};
    end
  end

  a_flag_status: assert property (@(posedge clk) disable iff (rst)
    !interrupt_flag |-> status_value == tsc_pkg::StNone)
    else $error("status code set without interrupt flag");

  a_ctrl_kept: assert property (@(posedge clk) disable iff (rst)
    (control_bits & ~tsc_pkg::KeepMask) == '0)
    else $error("control register holds a bit that is not kept");

  a_addr_reply: assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.op == tsc_pkg::OP_ADDR_RECV) |=> m_tvalid && m_tdata[9])
    else $error("address item gave no slave reply");

endmodule

// ===== rtl/twi_status_and_control_core.sv =====
// Register and status front end of a two-wire bus controller. CPU register
// writes and bus engine events arrive as input items (op in s_tuser); each
// produces exactly one result item carrying the engine command (m_tuser),
// ack replies, status code, interrupt request and register read values.
// The block takes one item per clock cycle while the queue is not full: a
// front stage classifies each item into a queue of QUEUE_DEPTH entries, and
// the back stage retires one queue entry per cycle into the output register
// while that register is empty or being taken, so a result passes through
// the queue and then the output register. Each side may stall on its own
// until the queue fills. Configuration writes (index 0 own address, 1 address
// mask, 2 general call enable) are always ready and take effect at once.
module twi_status_and_control_core #(
  parameter int QUEUE_DEPTH = tsc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // byte_value[7:0], ack_seen[8], from_master[9], start_granted[10],
  // master_phase[13:11], master_active[14], master_busy[15],
  // slave_active[16], slave_busy[17], zero[23:18]
  input  logic [23:0] s_tdata,
  // op[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // command_byte[7:0], engine_enable[8], slave_ack_valid[9], slave_ack[10],
  // master_ack_valid[11], master_ack[12], status_code[17:13],
  // irq_request[18], data_value[26:19], control_value[34:27], zero[39:35]
  output logic [39:0] m_tdata,
  // engine_command[2:0]
  output logic [2:0]  m_tuser
);

  logic           push;
  tsc_pkg::item_t push_item;
  logic           queue_full;
  logic           pop;
  logic           head_valid;
  tsc_pkg::item_t head_item;

  assign cfg_ready = 1'b1;

  tsc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  tsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tsc_pkg::op_t op;
    logic [7:0]   bv;
    logic         ack;
    logic         fm;
    logic         gr;
    logic [2:0]   ph;
    logic         m_act;
    logic         m_busy;
    logic         s_act;
    logic         s_busy;
  } access_t;

  typedef struct packed {
    tsc_pkg::cmd_t cmd;
    logic [7:0]    cbyte;
    logic          en;
    logic          sav;
    logic          sa;
    logic          mav;
    logic          ma;
    logic [4:0]    status;
    logic          irq;
    logic [7:0]    data;
    logic [7:0]    ctrl;
  } reply_t;

  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  // Copy of the block's registers and state, advanced once per accepted item.
  logic [6:0] cfg_own = tsc_pkg::OwnAddrReset;
  logic [6:0] cfg_mask = '0;
  logic       cfg_gc = 1'b0;
  logic [7:0] ctl_bits = '0;
  logic       int_flag = 1'b0;
  logic [4:0] st_code = tsc_pkg::StNone;
  logic [7:0] data_byte = tsc_pkg::DataReset;
  logic       gc_mode = 1'b0;
  logic       rx_dir = 1'b0;

  access_t access_q[$];
  reply_t  reply_q[$];
  access_t src_item;
  int      queued_cnt = 0;
  int      acc_cnt = 0;
  int      fail_cnt = 0;
  int      src_wait = 0;
  int      snk_wait = 0;
  int      cycles = 0;
  logic    src_calm = 1'b0;
  logic    snk_calm = 1'b0;

  twi_status_and_control_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void status_set(logic [7:0] code);
    st_code = code[7:3];
    int_flag = 1'b1;
  endfunction

  function automatic void status_clear();
    st_code = tsc_pkg::StNone;
    int_flag = 1'b0;
  endfunction

  function automatic reply_t frontend_step(access_t it);
    reply_t     r;
    logic       acken;
    logic [6:0] a;
    r = '0;
    r.cmd = tsc_pkg::CMD_NONE;
    acken = ctl_bits[tsc_pkg::BitAcken];
    case (it.op)
      tsc_pkg::OP_CTRL_WRITE: begin
        ctl_bits = it.bv & tsc_pkg::KeepMask;
        if (it.bv[tsc_pkg::BitInt]) status_clear();
        // Commands go out only with the enable bit and no pending flag.
        if (it.bv[tsc_pkg::BitEn] && !int_flag) begin
          if (it.bv[tsc_pkg::BitStop]) begin
            r.cmd = tsc_pkg::CMD_STOP;
          end else if (it.bv[tsc_pkg::BitStart]) begin
            r.cmd = tsc_pkg::CMD_START;
            if (it.gr) status_set(tsc_pkg::StStart);
          end else if (it.ph == tsc_pkg::PH_WAITING) begin
            r.cmd = tsc_pkg::CMD_RESET_ARB;
          end else if (it.ph == tsc_pkg::PH_ADDRESS) begin
            rx_dir = data_byte[0];
            r.cmd = tsc_pkg::CMD_SEND_ADDR;
            r.cbyte = data_byte;
          end else if (it.ph == tsc_pkg::PH_TRANSMIT) begin
            r.cmd = tsc_pkg::CMD_MASTER_TX;
            r.cbyte = data_byte;
          end else if (it.ph == tsc_pkg::PH_RECEIVE) begin
            r.cmd = tsc_pkg::CMD_MASTER_RX;
          end
        end
      end
      tsc_pkg::OP_DATA_WRITE: begin
        if ((it.m_act && !it.m_busy) || (it.s_act && !it.s_busy)) data_byte = it.bv;
      end
      tsc_pkg::OP_BUS_IDLE: begin
        if (ctl_bits[tsc_pkg::BitStart]) begin
          r.cmd = tsc_pkg::CMD_START;
          if (it.gr) status_set(tsc_pkg::StStart);
        end
        if (it.s_act) status_set(tsc_pkg::StSrStop);
      end
      tsc_pkg::OP_ADDR_RECV: begin
        a = it.bv[7:1];
        data_byte = it.bv;
        r.sav = 1'b1;
        if (acken) begin
          if (a == 7'd0) begin
            if (!it.bv[0] && cfg_gc) begin
              r.sa = 1'b1;
              gc_mode = 1'b1;
              rx_dir = 1'b1;
              status_set(tsc_pkg::StSrGenCall);
            end
          end else if ((a | cfg_mask) == (cfg_own | cfg_mask)) begin
            r.sa = 1'b1;
            gc_mode = 1'b0;
            rx_dir = !it.bv[0];
            status_set(rx_dir ? tsc_pkg::StSrAddr : tsc_pkg::StStAddr);
          end
        end
      end
      tsc_pkg::OP_ADDR_ACK: begin
        if (it.ack) status_set(rx_dir ? tsc_pkg::StMrAddrAck : tsc_pkg::StMtAddrAck);
        else status_set(rx_dir ? tsc_pkg::StMrAddrNack : tsc_pkg::StMtAddrNack);
      end
      tsc_pkg::OP_TX_DONE: begin
        if (it.fm) status_set(it.ack ? tsc_pkg::StMtDataAck : tsc_pkg::StMtDataNack);
        else if (!it.ack) status_set(tsc_pkg::StStDataNack);
        else status_set(acken ? tsc_pkg::StStDataAck : tsc_pkg::StStLastAck);
      end
      tsc_pkg::OP_RX_DONE: begin
        data_byte = it.bv;
        if (it.fm) begin
          r.mav = 1'b1;
          r.ma = acken;
          status_set(acken ? tsc_pkg::StMrDataAck : tsc_pkg::StMrDataNack);
        end else begin
          r.sav = 1'b1;
          r.sa = acken;
          if (gc_mode) status_set(acken ? tsc_pkg::StSrGcAck : tsc_pkg::StSrGcNack);
          else status_set(acken ? tsc_pkg::StSrDataAck : tsc_pkg::StSrDataNack);
        end
      end
      default: begin
      end
    endcase
    r.en = ctl_bits[tsc_pkg::BitEn];
    r.status = st_code;
    r.irq = int_flag & ctl_bits[tsc_pkg::BitIe];
    r.data = data_byte;
    r.ctrl = ctl_bits | {int_flag, 7'd0};
    return r;
  endfunction

  function automatic int gap_draw(logic calm);
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic logic coin(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic rb();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [2:0] rph();
    return 3'($urandom_range(0, 4));
  endfunction

  function automatic logic [3:0] ract();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] ctrl_byte(logic clr, logic ak, logic st, logic sp, logic ie);
    return {clr, ak, st, sp, 1'b0, 1'b1, 1'b0, ie};
  endfunction

  // Mostly addresses that hit our own address under the mask, some general calls.
  function automatic logic [7:0] pick_addr();
    logic [6:0] a;
    int         r;
    r = $urandom_range(0, 99);
    a = 7'($urandom_range(0, 127));
    if (r < 60) a = (cfg_own & ~cfg_mask) | (a & cfg_mask);
    else if (r < 80) a = 7'd0;
    return {a, rb()};
  endfunction

  task automatic put(tsc_pkg::op_t op, logic [7:0] bv, logic ack, logic fm, logic gr,
                     logic [2:0] ph, logic [3:0] act);
    access_t it;
    it.op = op;
    it.bv = bv;
    it.ack = ack;
    it.fm = fm;
    it.gr = gr;
    it.ph = ph;
    {it.m_act, it.m_busy, it.s_act, it.s_busy} = act;
    access_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic cfg_write(tsc_pkg::cfg_index_t idx, logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tsc_pkg::CFG_OWN_ADDRESS:  cfg_own = val;
      tsc_pkg::CFG_ADDRESS_MASK: cfg_mask = val;
      tsc_pkg::CFG_GENCALL:      cfg_gc = val[0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (acc_cnt != queued_cnt || reply_q.size() != 0) @(negedge clk);
  endtask

  // Own address 0x2A, no mask, general call accepted.
  task automatic directed_items();
    put(tsc_pkg::OP_CTRL_WRITE, 8'h45, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_CTRL_WRITE, 8'h65, 1'b0, 1'b0, 1'b1, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_CTRL_WRITE, 8'h45, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_ADDRESS, 4'b0000);
    put(tsc_pkg::OP_DATA_WRITE, 8'h54, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b1000);
    put(tsc_pkg::OP_DATA_WRITE, 8'hAA, 1'b1, 1'b1, 1'b1, tsc_pkg::PH_OTHER, 4'b1101);
    put(tsc_pkg::OP_CTRL_WRITE, 8'hC5, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_ADDRESS, 4'b0000);
    put(tsc_pkg::OP_ADDR_ACK, 8'h00, 1'b1, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_DATA_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0010);
    put(tsc_pkg::OP_CTRL_WRITE, 8'hC5, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_TRANSMIT, 4'b0000);
    put(tsc_pkg::OP_TX_DONE, 8'h00, 1'b0, 1'b1, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_CTRL_WRITE, 8'hC5, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_RECEIVE, 4'b0000);
    put(tsc_pkg::OP_RX_DONE, 8'h00, 1'b0, 1'b1, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_CTRL_WRITE, 8'h85, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_WAITING, 4'b0000);
    put(tsc_pkg::OP_RX_DONE, 8'h7E, 1'b0, 1'b1, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    // Stop and start together with the flag cleared: stop wins.
    put(tsc_pkg::OP_CTRL_WRITE, 8'hF5, 1'b0, 1'b0, 1'b1, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_CTRL_WRITE, 8'hA4, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_BUS_IDLE, 8'hFF, 1'b1, 1'b1, 1'b1, tsc_pkg::PH_RECEIVE, 4'b1111);
    put(tsc_pkg::OP_CTRL_WRITE, 8'hC4, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_ADDR_RECV, 8'h54, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_ADDR_ACK, 8'h00, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_RX_DONE, 8'h12, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_ADDR_RECV, 8'h00, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_RX_DONE, 8'h80, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_ADDR_RECV, 8'h01, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_ADDR_RECV, 8'h55, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_TX_DONE, 8'h00, 1'b1, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_CTRL_WRITE, 8'h84, 1'b0, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
    put(tsc_pkg::OP_TX_DONE, 8'h00, 1'b1, 1'b0, 1'b0, tsc_pkg::PH_OTHER, 4'b0000);
  endtask

  task automatic master_run();
    logic [7:0] ab;
    logic       ak;
    logic       ie;
    int         n;
    ak = coin(80);
    ie = rb();
    ab = rbyte();
    put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, ak, 1'b1, 1'b0, ie), rb(), rb(), coin(80),
        rph(), ract());
    put(tsc_pkg::OP_DATA_WRITE, ab, rb(), rb(), rb(), rph(), {1'b1, coin(10), rb(), rb()});
    put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, ak, 1'b0, 1'b0, ie), rb(), rb(), rb(),
        tsc_pkg::PH_ADDRESS, ract());
    put(tsc_pkg::OP_ADDR_ACK, rbyte(), coin(85), rb(), rb(), rph(), ract());
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (!ab[0]) begin
        put(tsc_pkg::OP_DATA_WRITE, rbyte(), rb(), rb(), rb(), tsc_pkg::PH_TRANSMIT,
            {1'b1, coin(10), rb(), rb()});
        put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, ak, 1'b0, 1'b0, ie), rb(), rb(), rb(),
            tsc_pkg::PH_TRANSMIT, ract());
        put(tsc_pkg::OP_TX_DONE, rbyte(), coin(80), 1'b1, rb(), tsc_pkg::PH_TRANSMIT,
            ract());
      end else begin
        ak = coin(70);
        put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, ak, 1'b0, 1'b0, ie), rb(), rb(), rb(),
            tsc_pkg::PH_RECEIVE, ract());
        put(tsc_pkg::OP_RX_DONE, rbyte(), rb(), 1'b1, rb(), tsc_pkg::PH_RECEIVE, ract());
      end
    end
    if (coin(70))
      put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, ak, rb(), 1'b1, ie), rb(), rb(), rb(),
          rph(), ract());
  endtask

  task automatic slave_run();
    logic [7:0] ab;
    logic       ie;
    int         n;
    ie = rb();
    put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, coin(85), 1'b0, 1'b0, ie), rb(), rb(), rb(),
        tsc_pkg::PH_OTHER, ract());
    ab = pick_addr();
    put(tsc_pkg::OP_ADDR_RECV, ab, rb(), rb(), rb(), rph(), ract());
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (!ab[0]) begin
        put(tsc_pkg::OP_RX_DONE, rbyte(), rb(), 1'b0, rb(), tsc_pkg::PH_OTHER, ract());
        put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, coin(80), 1'b0, 1'b0, ie), rb(), rb(),
            rb(), tsc_pkg::PH_OTHER, ract());
      end else begin
        put(tsc_pkg::OP_DATA_WRITE, rbyte(), rb(), rb(), rb(), tsc_pkg::PH_OTHER,
            {rb(), rb(), 1'b1, coin(10)});
        put(tsc_pkg::OP_CTRL_WRITE, ctrl_byte(1'b1, coin(80), 1'b0, 1'b0, ie), rb(), rb(),
            rb(), tsc_pkg::PH_OTHER, ract());
        put(tsc_pkg::OP_TX_DONE, rbyte(), coin(75), 1'b0, rb(), tsc_pkg::PH_OTHER, ract());
      end
    end
    put(tsc_pkg::OP_BUS_IDLE, rbyte(), rb(), rb(), rb(), rph(),
        {rb(), rb(), coin(80), rb()});
  endtask

  task automatic noise_run();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      put(tsc_pkg::op_t'(3'($urandom_range(0, 6))), rbyte(), rb(), rb(), rb(),
          rph(), ract());
  endtask

  initial begin
    int         goal;
    int         r;
    logic [6:0] own;
    logic [6:0] msk;
    logic       gc;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int pi = 0; pi < 7; pi++) begin
      wait_drained();
      own = 7'($urandom_range(0, 127));
      msk = 7'($urandom_range(0, 127));
      gc = rb();
      case (pi)
        0: begin own = 7'h2A; msk = 7'h00; gc = 1'b1; end
        1: begin msk = 7'h00; gc = 1'b1; end
        2: begin own = 7'h00; msk = 7'h7F; gc = 1'b0; end
        3: begin own = 7'h7F; gc = 1'b1; end
        4: begin own = 7'h7F; msk = 7'h00; gc = 1'b0; end
        default: begin
        end
      endcase
      cfg_write(tsc_pkg::CFG_OWN_ADDRESS, own);
      cfg_write(tsc_pkg::CFG_ADDRESS_MASK, msk);
      cfg_write(tsc_pkg::CFG_GENCALL, {6'd0, gc});
      src_calm = (pi % 3 == 2);
      snk_calm = (pi % 3 == 1);
      if (pi == 0) begin
        directed_items();
      end else begin
        goal = queued_cnt + 310;
        while (queued_cnt < goal) begin
          r = $urandom_range(0, 99);
          if (r < 35) master_run();
          else if (r < 75) slave_run();
          else noise_run();
        end
      end
    end
    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Source side: presents queued items, with a drawn pause after each one.
  always @(posedge clk) begin
    logic    hold;
    access_t nxt;
    hold = s_tvalid && !s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        reply_q.push_back(frontend_step(src_item));
        acc_cnt <= acc_cnt + 1;
      end
      if (!hold) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          s_tvalid <= 1'b0;
        end else if (access_q.size() != 0) begin
          nxt = access_q.pop_front();
          src_item <= nxt;
          s_tdata <= {6'd0, nxt.s_busy, nxt.s_act, nxt.m_busy, nxt.m_act, nxt.ph,
                      nxt.gr, nxt.fm, nxt.ack, nxt.bv};
          s_tuser <= nxt.op;
          s_tvalid <= 1'b1;
          src_wait <= gap_draw(src_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Sink side: checks each result item and stalls for a drawn pause after it.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    int     w;
    if (rst) begin
      m_tready <= 1'b1;
      snk_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      got.cmd = tsc_pkg::cmd_t'(m_tuser);
      got.cbyte = m_tdata[7:0];
      got.en = m_tdata[8];
      got.sav = m_tdata[9];
      got.sa = m_tdata[10];
      got.mav = m_tdata[11];
      got.ma = m_tdata[12];
      got.status = m_tdata[17:13];
      got.irq = m_tdata[18];
      got.data = m_tdata[26:19];
      got.ctrl = m_tdata[34:27];
      if (reply_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_cnt++;
      end else begin
        want = reply_q.pop_front();
        check_field("engine_command", int'(want.cmd), int'(got.cmd));
        check_field("command_byte", int'(want.cbyte), int'(got.cbyte));
        check_field("engine_enable", int'(want.en), int'(got.en));
        check_field("slave_ack_valid", int'(want.sav), int'(got.sav));
        check_field("slave_ack", int'(want.sa), int'(got.sa));
        check_field("master_ack_valid", int'(want.mav), int'(got.mav));
        check_field("master_ack", int'(want.ma), int'(got.ma));
        check_field("status_code", int'(want.status), int'(got.status));
        check_field("irq_request", int'(want.irq), int'(got.irq));
        check_field("data_value", int'(want.data), int'(got.data));
        check_field("control_value", int'(want.ctrl), int'(got.ctrl));
      end
      w = gap_draw(snk_calm);
      if (w != 0) begin
        m_tready <= 1'b0;
        snk_wait <= w - 1;
      end
    end else if (!m_tready) begin
      if (snk_wait == 0) m_tready <= 1'b1;
      else snk_wait <= snk_wait - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
